// ===== rtl/ktrs_pkg.sv =====
// -----------------------------------------------------------------------------
// ktrs_pkg: shared types and constants of the keyed table rank select block
// Request and response payloads, the stored row layout, the sequencer
// states and the control group that passes from the sequencer to the datapath.
// -----------------------------------------------------------------------------
package ktrs_pkg;

   // Table depth used when the top level is not told otherwise.
   localparam int DEPTH_DEFAULT = 16;

   localparam int KEY_W  = 32;
   localparam int WORD_W = 64;

   // Function codes of a request.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic                     func;
      logic signed [KEY_W-1:0]  marker_key;
      logic [WORD_W-1:0]        pos_x;
      logic [WORD_W-1:0]        pos_y;
      logic [WORD_W-1:0]        pos_z;
      logic [WORD_W-1:0]        rot_x;
      logic [WORD_W-1:0]        rot_y;
      logic [WORD_W-1:0]        rot_z;
      logic [WORD_W-1:0]        rot_w;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] out_pos_x;
      logic [WORD_W-1:0] out_pos_y;
      logic [WORD_W-1:0] out_pos_z;
      logic [WORD_W-1:0] out_rot_x;
      logic [WORD_W-1:0] out_rot_y;
      logic [WORD_W-1:0] out_rot_z;
      logic [WORD_W-1:0] out_rot_w;
   } rsp_type;

   // Seven pose words in the order they appear on both channels.
   typedef struct packed {
      logic [WORD_W-1:0] pos_x;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_z;
      logic [WORD_W-1:0] rot_x;
      logic [WORD_W-1:0] rot_y;
      logic [WORD_W-1:0] rot_z;
      logic [WORD_W-1:0] rot_w;
   } pose_type;

   // One table row: rows are kept sorted by key, so the row index is the rank.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      pose_type                pose;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_WRITE,
      ST_QWAIT,
      ST_RESP
   } state_type;

   // Where the response pose comes from.
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_REQ,
      SRC_MEM
   } src_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic       wr_shift;
      logic       rsp_load;
      logic [1:0] status;
      src_type    src;
   } ctrl_type;

endpackage

// ===== rtl/keyed_table_rank_select.sv =====
// -----------------------------------------------------------------------------
// keyed_table_rank_select: order-statistic key/value table
// Stores poses under signed keys in rows kept sorted by key, so a rank query
// is a single row read; inserts scan for the key and shift rows to make room.
// -----------------------------------------------------------------------------
//  port group  direction  payload     accepted when
//  req_        in         req_type    req_valid && req_ready
//  rsp_        out        rsp_type    rsp_valid && rsp_ready
//
//  A query response is valid after decode and a row read, or straight after
//  decode when the table is empty or the rank is out of range.
//  An insert decodes, scans rows one per cycle up to the key or insertion point,
//  moves each row above that point up by one, then writes, unless the key is new and the table full.
//  Reset clears the entry count and the sequencer; rows need no clearing.
//  A new request is taken only in the cycle after the previous response is taken.
// -----------------------------------------------------------------------------
module keyed_table_rank_select #(
   parameter int DEPTH = ktrs_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ktrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ktrs_pkg::rsp_type rsp_data
);
   import ktrs_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   req_type       req_ff;
   rsp_type       rsp_ff;
   row_type       mem_ff [0:DEPTH-1];
   row_type       rd_row_ff;
   row_type       wr_row;
   pose_type      req_pose;
   pose_type      rsp_pose;
   ctrl_type      ctrl;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;

   ktrs_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_ff.func),
      .req_key   (req_ff.marker_key),
      .rd_key    (rd_row_ff.key),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   assign req_pose = '{pos_x: req_ff.pos_x, pos_y: req_ff.pos_y, pos_z: req_ff.pos_z,
                       rot_x: req_ff.rot_x, rot_y: req_ff.rot_y, rot_z: req_ff.rot_z,
                       rot_w: req_ff.rot_w};

   // A shift moves the row just read; otherwise the request row is stored.
   assign wr_row = ctrl.wr_shift ? rd_row_ff
                                 : row_type'{key: req_ff.marker_key, pose: req_pose};

   // Row memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_row;
      end
      if (ctrl.rd_en) begin
         rd_row_ff <= mem_ff[rd_addr];
      end
   end

   // Response pose selection.
   always_comb begin
      case (ctrl.src)
         SRC_REQ: rsp_pose = req_pose;
         SRC_MEM: rsp_pose = rd_row_ff.pose;
         default: rsp_pose = '0;
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_ff <= '{status: ctrl.status,
                     out_pos_x: rsp_pose.pos_x, out_pos_y: rsp_pose.pos_y,
                     out_pos_z: rsp_pose.pos_z, out_rot_x: rsp_pose.rot_x,
                     out_rot_y: rsp_pose.rot_y, out_rot_z: rsp_pose.rot_z,
                     out_rot_w: rsp_pose.rot_w};
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/ktrs_ctrl.sv =====
// -----------------------------------------------------------------------------
// ktrs_ctrl: sequencer of the keyed table rank select block
// Walks the sorted table one row per cycle through a single signed key
// comparator, shifts rows up to open an insertion point and keeps the count.
// -----------------------------------------------------------------------------
module ktrs_ctrl #(
   parameter int DEPTH = ktrs_pkg::DEPTH_DEFAULT,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic signed [ktrs_pkg::KEY_W-1:0] req_key,
   input  logic signed [ktrs_pkg::KEY_W-1:0] rd_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ktrs_pkg::ctrl_type               ctrl,
   output logic [IW-1:0]                    rd_addr,
   output logic [IW-1:0]                    wr_addr
);
   import ktrs_pkg::*;

   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          new_ff, new_in;
   logic [CW-1:0] count_ff, count_in;

   logic          empty;
   logic          full;
   logic          range_bad;
   logic          key_eq;
   logic          key_gt;
   logic          last_scan;
   logic [IW-1:0] idx_inc;
   logic [IW-1:0] idx_dec;
   logic [IW-1:0] top_row;

   // Shared comparator and table bookkeeping.
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign range_bad = req_key[KEY_W-1] || (req_key[KEY_W-2:0] >= (KEY_W-1)'(count_ff));
   assign key_eq    = (rd_key == req_key);
   assign key_gt    = (rd_key > req_key);
   assign last_scan = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign idx_inc   = IW'(CW'(idx_ff) + CW'(1));
   assign idx_dec   = idx_ff - IW'(1);
   assign top_row   = IW'(count_ff - CW'(1));

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      new_in   = new_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (req_func == FUNC_QUERY) begin
               state_in = (empty || range_bad) ? ST_RESP : ST_QWAIT;
            end else if (empty) begin
               pos_in   = '0;
               new_in   = 1'b1;
               state_in = ST_WRITE;
            end else begin
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (key_eq) begin
               pos_in   = idx_ff;
               new_in   = 1'b0;
               state_in = ST_WRITE;
            end else if (key_gt || last_scan) begin
               new_in = 1'b1;
               if (full) begin
                  state_in = ST_RESP;
               end else if (key_gt) begin
                  // Open a hole at this row by moving the upper rows up by one.
                  pos_in   = idx_ff;
                  idx_in   = top_row;
                  state_in = ST_SHIFT;
               end else begin
                  pos_in   = idx_inc;
                  state_in = ST_WRITE;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         ST_SHIFT: begin
            if (idx_ff == pos_ff) begin
               state_in = ST_WRITE;
            end else begin
               idx_in = idx_dec;
            end
         end
         ST_WRITE: begin
            if (new_ff) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_RESP;
         end
         ST_QWAIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs toward the datapath.
   always_comb begin
      ctrl          = '{rd_en: 1'b0, wr_en: 1'b0, wr_shift: 1'b0, rsp_load: 1'b0,
                        status: STATUS_OK, src: SRC_ZERO};
      rd_addr       = '0;
      wr_addr       = '0;
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_RESP);
      case (state_ff)
         ST_DECODE: begin
            if (req_func == FUNC_QUERY) begin
               if (empty) begin
                  ctrl.rsp_load = 1'b1;
                  ctrl.status   = STATUS_EMPTY;
               end else if (range_bad) begin
                  ctrl.rsp_load = 1'b1;
                  ctrl.status   = STATUS_RANGE;
               end else begin
                  ctrl.rd_en = 1'b1;
                  rd_addr    = req_key[IW-1:0];
               end
            end else if (!empty) begin
               ctrl.rd_en = 1'b1;
               rd_addr    = '0;
            end
         end
         ST_SCAN: begin
            if (!key_eq && (key_gt || last_scan)) begin
               if (full) begin
                  ctrl.rsp_load = 1'b1;
                  ctrl.status   = STATUS_FULL;
               end else if (key_gt) begin
                  ctrl.rd_en = 1'b1;
                  rd_addr    = top_row;
               end
            end else if (!key_eq) begin
               ctrl.rd_en = 1'b1;
               rd_addr    = idx_inc;
            end
         end
         ST_SHIFT: begin
            ctrl.wr_en    = 1'b1;
            ctrl.wr_shift = 1'b1;
            wr_addr       = idx_inc;
            if (idx_ff != pos_ff) begin
               ctrl.rd_en = 1'b1;
               rd_addr    = idx_dec;
            end
         end
         ST_WRITE: begin
            ctrl.wr_en    = 1'b1;
            wr_addr       = pos_ff;
            ctrl.rsp_load = 1'b1;
            ctrl.src      = SRC_REQ;
         end
         ST_QWAIT: begin
            ctrl.rsp_load = 1'b1;
            ctrl.src      = SRC_MEM;
         end
         default: begin
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         pos_ff   <= '0;
         new_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         new_ff   <= new_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   // The entry count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // The count only grows, by one, on the write that adds a new key.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + CW'(1)) && ($past(state_ff) == ST_WRITE))
      else $error("entry count changed outside an insert");

   // While shifting, the moving row stays at or above the insertion point.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (idx_ff >= pos_ff))
      else $error("shift ran below the insertion point");

   // A new key is never written into a full table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && new_ff) |-> !full)
      else $error("new key written into a full table");

   // A response is loaded only while no response is pending.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> !rsp_valid)
      else $error("response overwritten while pending");
`endif

endmodule
